### rtl/capacitive_dial_station_lock_unit_defines.svh
// Assertion macros for the checker file of the station lock unit.
`ifndef CAPACITIVE_DIAL_STATION_LOCK_UNIT_DEFINES_SVH
`define CAPACITIVE_DIAL_STATION_LOCK_UNIT_DEFINES_SVH

// A plain property, which is checked at every clock edge outside reset.
`define CDSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A property where the consequent must hold in the cycle after the antecedent.
`define CDSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cdsl_pkg.sv
// Types and constants shared by the station lock unit.
`timescale 1ns / 1ps
package cdsl_pkg;

  // Width of a station index inside the scan token; covers up to 256 stations.
  localparam int unsigned IdxW = 8;

  // Register offsets on the configuration port, in words.
  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_NUMER = 2'd1;
  localparam logic [1:0] REG_CONN  = 2'd2;
  localparam logic [1:0] REG_DISC  = 2'd3;

  // Request kinds.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_MEAS  = 1'b1;

  // Lock event codes.
  localparam logic [1:0] EVT_NONE   = 2'd0;
  localparam logic [1:0] EVT_LOCK   = 2'd1;
  localparam logic [1:0] EVT_UNLOCK = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  entry_index;
    logic [23:0] target_capacitance;
    logic [14:0] gate_count;
  } in_t;

  typedef struct packed {
    logic [31:0] capacitance_q8;
    logic        locked;
    logic [3:0]  station_index;
    logic [6:0]  radio_weight;
    logic [6:0]  noise_weight;
    logic [1:0]  lock_event;
    logic        stream_restart;
  } out_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic            vld;
    logic [31:0]     cap;
    logic            found;
    logic [31:0]     best_d;
    logic [IdxW-1:0] best_idx;
    logic [31:0]     act_d;
  } tok_t;

endpackage

### rtl/capacitive_dial_station_lock_unit.sv
// Top level of the capacitive dial station lock unit.
// A write request stores one station target in its cell.
// A measurement request runs the capacitance division in the serial divider
// (an operand load and 32 steps), hands the scan token through the MAX_STATIONS
// station cells and judges it as it leaves the last cell, runs the divider again
// when a weight is due, and then loads the output register. A zero gate count
// skips the first division. The next request is taken once the result is
// loaded. One request is in work at a time; a finished result waits in the
// output register while the next request is taken, and a request stalls before
// its result only while that register is still full.
`timescale 1ns / 1ps
module capacitive_dial_station_lock_unit #(
  parameter int unsigned MAX_STATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cdsl_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cdsl_pkg::out_t     out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cdsl_pkg::*;

  localparam int unsigned AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CAP, S_SCAN, S_WGT, S_OUT
  } state_e;

  state_e      state_q;
  logic [4:0]  cnt_q;
  logic [31:0] num_q;
  logic [15:0] con_q;
  logic [15:0] dis_q;
  logic [31:0] cap_q;
  logic        lock_q;
  logic [AW-1:0] act_q;
  logic [1:0]  evt_q;
  logic [6:0]  radio_q;
  logic        ovld_q;
  out_t        out_q;

  logic        accept;
  logic        wr_en;
  logic        div_start;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [31:0] div_quo;
  tok_t        tok_first;
  tok_t        tok [MAX_STATIONS+1];
  tok_t        tok_last;

  // Scan decision.
  logic        locked_eff;
  logic [31:0] wd;
  logic        n_lock;
  logic [AW-1:0] n_act;
  logic [1:0]  n_evt;
  logic        need_div;
  logic [6:0]  n_radio;
  logic [22:0] w_num;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
      num_q <= 32'd1755428571;
      con_q <= 16'd1408;
      dis_q <= 16'd1664;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_COUNT: cnt_q <= pwdata[4:0];
        REG_NUMER: num_q <= pwdata;
        REG_CONN:  con_q <= pwdata[15:0];
        REG_DISC:  dis_q <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      REG_COUNT: prdata = {27'd0, cnt_q};
      REG_NUMER: prdata = num_q;
      REG_CONN:  prdata = {16'd0, con_q};
      REG_DISC:  prdata = {16'd0, dis_q};
      default:   prdata = '0;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && (in_data_i.req_type == REQ_WRITE) &&
                      (32'(in_data_i.entry_index) < MAX_STATIONS);

  // Scan token injection into the first cell.
  always_comb begin
    tok_first       = '0;
    tok_first.vld   = (accept && (in_data_i.req_type == REQ_MEAS) &&
                       (in_data_i.gate_count == 15'd0)) ||
                      ((state_q == S_CAP) && div_done);
    tok_first.cap   = (state_q == S_IDLE) ? 32'd0 : div_quo;
  end
  assign tok[0] = tok_first;

  // Row of station cells.
  for (genvar g = 0; g < MAX_STATIONS; g++) begin : g_cell
    cdsl_cell #(
      .CellIdx (g),
      .AW      (AW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en),
      .wr_idx_i  (in_data_i.entry_index),
      .wr_data_i (in_data_i.target_capacitance),
      .count_i   (cnt_q),
      .act_i     (act_q),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end
  assign tok_last = tok[MAX_STATIONS];

  // Lock decision once the token leaves the last cell.
  always_comb begin
    locked_eff = lock_q && (32'(act_q) < 32'(cnt_q));
    n_lock     = lock_q;
    n_act      = act_q;
    n_evt      = EVT_NONE;
    wd         = 32'd0;
    need_div   = 1'b0;
    n_radio    = 7'd0;
    if (locked_eff) begin
      if (tok_last.act_d > 32'(dis_q)) begin
        n_lock = 1'b0;
        n_act  = '0;
        n_evt  = EVT_UNLOCK;
      end else begin
        wd       = tok_last.act_d;
        need_div = 1'b1;
      end
    end else if (tok_last.found && (tok_last.best_d <= 32'(con_q))) begin
      n_lock   = 1'b1;
      n_act    = AW'(tok_last.best_idx);
      n_evt    = EVT_LOCK;
      wd       = tok_last.best_d;
      need_div = 1'b1;
    end
    // Weight edge cases that need no division.
    if (need_div && (dis_q == 16'd0)) begin
      need_div = 1'b0;
      n_radio  = (wd == 32'd0) ? 7'd100 : 7'd0;
    end else if (need_div && (wd >= 32'(dis_q))) begin
      need_div = 1'b0;
    end
    w_num = 23'(dis_q - wd[15:0]) * 23'd100;
  end

  // Divider operand selection.
  always_comb begin
    if (state_q == S_IDLE) begin
      div_start    = accept && (in_data_i.req_type == REQ_MEAS) &&
                     (in_data_i.gate_count != 15'd0);
      div_dividend = num_q;
      div_divisor  = {1'b0, in_data_i.gate_count};
    end else begin
      div_start    = (state_q == S_SCAN) && tok_last.vld && need_div;
      div_dividend = {9'd0, w_num};
      div_divisor  = dis_q;
    end
  end

  cdsl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // Sequencer with lock state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lock_q  <= 1'b0;
      act_q   <= '0;
      evt_q   <= EVT_NONE;
      radio_q <= 7'd0;
      cap_q   <= 32'd0;
      ovld_q  <= 1'b0;
      out_q   <= '0;
    end else begin
      if (out_ready_i && (state_q != S_OUT)) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (in_data_i.req_type == REQ_MEAS)) begin
            if (in_data_i.gate_count == 15'd0) begin
              cap_q   <= 32'd0;
              state_q <= S_SCAN;
            end else begin
              state_q <= S_CAP;
            end
          end
        end
        S_CAP: begin
          if (div_done) begin
            cap_q   <= div_quo;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok_last.vld) begin
            lock_q  <= n_lock;
            act_q   <= n_act;
            evt_q   <= n_evt;
            radio_q <= n_radio;
            state_q <= need_div ? S_WGT : S_OUT;
          end
        end
        S_WGT: begin
          if (div_done) begin
            radio_q <= div_quo[6:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovld_q || out_ready_i) begin
            ovld_q               <= 1'b1;
            out_q.capacitance_q8 <= cap_q;
            out_q.locked         <= lock_q;
            out_q.station_index  <= 4'(act_q);
            out_q.radio_weight   <= radio_q;
            out_q.noise_weight   <= 7'd100 - radio_q;
            out_q.lock_event     <= evt_q;
            out_q.stream_restart <= (evt_q != EVT_NONE);
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;
endmodule

### rtl/cdsl_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cdsl_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [15:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [16:0] shifted;

  // Shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = 16'(shifted - {1'b0, dvs_q});
      quo_d = {quo_q[30:0], 1'b1};
    end else begin
      rem_d = shifted[15:0];
      quo_d = {quo_q[30:0], 1'b0};
    end
  end

  // Control: run 32 steps, then pulse done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

### rtl/cdsl_cell.sv
// One station cell: holds a table entry and updates the passing scan token.
`timescale 1ns / 1ps
module cdsl_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned AW      = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [3:0]         wr_idx_i,
  input  logic [23:0]        wr_data_i,
  input  logic [4:0]         count_i,
  input  logic [AW-1:0]      act_i,
  input  cdsl_pkg::tok_t     tok_i,
  output cdsl_pkg::tok_t     tok_o
);
  import cdsl_pkg::*;

  logic [23:0] entry_q;
  tok_t        tok_q, tok_d;
  logic [31:0] gap;
  logic        in_use;

  // Table entry write.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_idx_i) == CellIdx)) begin
      entry_q <= wr_data_i;
    end
  end

  // Distance to this station and the running minimum.
  always_comb begin
    gap    = (tok_i.cap > 32'(entry_q)) ? tok_i.cap - 32'(entry_q)
                                        : 32'(entry_q) - tok_i.cap;
    in_use = CellIdx < 32'(count_i);
    tok_d  = tok_i;
    if (in_use && (!tok_i.found || gap < tok_i.best_d)) begin
      tok_d.found    = 1'b1;
      tok_d.best_d   = gap;
      tok_d.best_idx = IdxW'(CellIdx);
    end
    if (32'(act_i) == CellIdx) begin
      tok_d.act_d = gap;
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
endmodule

### rtl/cdsl_checker.sv
// Port-level checker for the station lock unit, bound to the top level.
`timescale 1ns / 1ps
`include "capacitive_dial_station_lock_unit_defines.svh"
module cdsl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cdsl_pkg::out_t out_data_o
);
  import cdsl_pkg::*;

  // The weights always share one hundred percent.
  `CDSL_ASSERT(a_weight_sum, !out_valid_o || (out_data_o.radio_weight + out_data_o.noise_weight == 7'd100), "weights do not sum to 100")

  // A restart pulse goes with every lock change and nothing else.
  `CDSL_ASSERT(a_restart, !out_valid_o || (out_data_o.stream_restart == (out_data_o.lock_event != EVT_NONE)), "restart does not match event")

  // An unlock leaves no station selected; a new lock reports locked.
  `CDSL_ASSERT(a_event_state, !out_valid_o || ((out_data_o.lock_event != EVT_UNLOCK || (!out_data_o.locked && out_data_o.station_index == 4'd0 && out_data_o.radio_weight == 7'd0)) && (out_data_o.lock_event != EVT_LOCK || out_data_o.locked)), "lock event and state disagree")

  // A stalled result holds.
  `CDSL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")
endmodule

bind capacitive_dial_station_lock_unit cdsl_checker u_cdsl_checker (.*);
